// File: sv/ffa_pkg.sv
// Package for the first-fit allocator: sizes, command and status codes, payload structs.
// No dependencies.
`timescale 1ns / 1ps
package ffa_pkg;
    localparam int MEM_UNITS   = 128;
    localparam int MAX_BLOCKS  = 128;
    localparam int HANDLE_BITS = 16;
    localparam int ADDR_W      = $clog2(MEM_UNITS + 1);
    localparam int CNT_W       = $clog2(MAX_BLOCKS + 1);
    localparam int IDX_W       = $clog2(MAX_BLOCKS);

    localparam logic [1:0] ACT_ALLOC  = 2'd0;
    localparam logic [1:0] ACT_ERASE  = 2'd1;
    localparam logic [1:0] ACT_DEFRAG = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NULL    = 2'd1;
    localparam logic [1:0] ST_ILLEGAL = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  alloc_length;
        logic [15:0] erase_handle;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] new_handle;
    } t_out_item;

    // One table entry as held in a cell.
    typedef struct packed {
        logic                   valid;
        logic [HANDLE_BITS-1:0] handle;
        logic [ADDR_W-1:0]      start;
        logic [ADDR_W-1:0]      length;
    } t_entry;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic                   ins;      // insert new entry at first-fit position
        logic [ADDR_W-1:0]      ins_len;
        logic [HANDLE_BITS-1:0] ins_handle;
        logic                   del;      // remove entry matching del_handle
        logic [HANDLE_BITS-1:0] del_handle;
        logic                   pack;     // compaction
    } t_cell_ctl;

    // Scan token carried along the chain, one cell per cycle.
    typedef struct packed {
        logic              go;       // token present at this cell
        logic              found;    // a fit or match lies upstream
        logic [ADDR_W-1:0] prev_end;
    } t_token;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;
endpackage

// File: sv/ffa_cell.sv
// One table slot of the allocator chain: holds an entry, scans and shifts with neighbors.
// Depends on ffa_pkg.
`timescale 1ns / 1ps
module ffa_cell
    import ffa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  logic      i_upd,      // apply the committed operation
    input  logic      i_first,    // this is slot 0
    input  logic      i_last,     // no slot follows
    input  t_entry    i_prev,     // entry of the slot before
    input  t_entry    i_next,     // entry of the slot after
    input  t_token    i_tok,
    input  logic [ADDR_W-1:0] i_size,
    output t_token    o_tok,
    output t_entry    o_entry
);
    t_entry r_e, n_e;
    t_token r_tok, n_tok;
    logic   r_hit, r_up;
    logic [ADDR_W-1:0] r_pe;
    logic   fit, here;
    logic [ADDR_W-1:0] gap_end, my_end;

    // A valid entry bounds the gap; the first invalid slot closes it with the size.
    assign gap_end = r_e.valid ? r_e.start : i_size;
    assign fit = !i_tok.found && (gap_end >= i_tok.prev_end)
                 && ((gap_end - i_tok.prev_end) >= i_ctl.ins_len)
                 && (r_e.valid || i_first || i_prev.valid);
    assign my_end = r_e.start + r_e.length;

    always_comb begin
        n_tok = i_tok;
        here  = 1'b0;
        if (i_ctl.del) begin
            here = !i_tok.found && r_e.valid && (r_e.handle == i_ctl.del_handle);
            n_tok.found = i_tok.found || here;
        end else if (i_ctl.pack) begin
            // token carries the packed end so far
            n_tok.prev_end = r_e.valid ? (i_tok.prev_end + r_e.length) : i_tok.prev_end;
        end else begin
            here = fit;
            n_tok.found = i_tok.found || here;
            if (r_e.valid && my_end > i_tok.prev_end) n_tok.prev_end = my_end;
        end
        if (!i_tok.go) n_tok = '0;
    end
    assign o_tok   = r_tok;
    assign o_entry = r_e;

    // Commit uses the flags captured as the token went by.
    always_comb begin
        n_e = r_e;
        if (i_upd) begin
            if (i_ctl.ins) begin
                if (r_hit) begin
                    n_e.valid = 1'b1;  n_e.handle = i_ctl.ins_handle;
                    n_e.start = r_pe;  n_e.length = i_ctl.ins_len;
                end else if (r_up) begin
                    n_e = i_prev;
                end
            end else if (i_ctl.del) begin
                if (r_hit || r_up) begin
                    n_e = i_last ? '0 : i_next;
                end
            end else if (i_ctl.pack) begin
                if (r_e.valid) n_e.start = r_pe;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e.valid <= 1'b0;
            r_tok     <= '0;
        end else begin
            r_e.valid <= n_e.valid;
            r_tok     <= n_tok;
        end
        r_e.handle <= n_e.handle;
        r_e.start  <= n_e.start;
        r_e.length <= n_e.length;
        if (i_tok.go) begin
            r_hit <= here;
            r_up  <= i_tok.found;
            r_pe  <= i_tok.prev_end;
        end
    end
endmodule

// File: sv/ffa_chain.sv
// Row of MAX_BLOCKS table cells; the scan token is registered in every cell.
// Depends on ffa_pkg and ffa_cell.
`timescale 1ns / 1ps
module ffa_chain
    import ffa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  logic      i_start,
    input  logic      i_upd,
    input  logic [ADDR_W-1:0] i_size,
    output logic      o_done,
    output logic      o_found,
    output logic      o_full
);
    t_entry e   [MAX_BLOCKS];
    t_token tok [MAX_BLOCKS+1];

    assign tok[0] = '{go: i_start, found: 1'b0, prev_end: '0};

    for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
        ffa_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (i_ctl),
            .i_upd   (i_upd),
            .i_first (g == 0),
            .i_last  (g == MAX_BLOCKS - 1),
            .i_prev  ((g == 0) ? '0 : e[(g == 0) ? 0 : g-1]),
            .i_next  ((g == MAX_BLOCKS - 1) ? '0 : e[(g == MAX_BLOCKS-1) ? g : g+1]),
            .i_tok   (tok[g]),
            .i_size  (i_size),
            .o_tok   (tok[g+1]),
            .o_entry (e[g])
        );
    end

    assign o_done  = tok[MAX_BLOCKS].go;
    assign o_found = tok[MAX_BLOCKS].found;
    assign o_full  = e[MAX_BLOCKS-1].valid;
endmodule

// File: sv/first_fit_allocator_with_compaction_core.sv
// First-fit allocator with compaction over a chain of table cells.
// The accepted item sets a start register that sends the scan token into cell 0; the
// token moves one cell per cycle, and table update and result register act as it
// leaves the last cell. No item is taken during the scan; a result left waiting
// holds off the next accept until it is taken. Reset (synchronous, active low): table
// empty, handle counter 0, mem_size 128. Depends on ffa_pkg, ffa_chain, ffa_cell.
`timescale 1ns / 1ps
module first_fit_allocator_with_compaction_core
    import ffa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);
    t_state r_state, n_state;
    logic [7:0]             r_size;
    logic [HANDLE_BITS-1:0] r_hcnt;
    t_in_item               r_cmd;
    t_out_item              r_out, n_out;
    logic                   r_outv, n_outv;
    logic                   r_start;
    logic                   accept, done;
    logic                   upd, found, full, ok_alloc;
    t_cell_ctl              ctl;
    logic [ADDR_W-1:0]      size_eff;

    // Effective size: clamp to MEM_UNITS.
    assign size_eff = (r_size > MEM_UNITS) ? ADDR_W'(MEM_UNITS) : ADDR_W'(r_size);

    // Alloc is possible only with a nonzero fitting length, free slot, handle room.
    assign ok_alloc = (r_cmd.alloc_length != 8'd0) && (r_cmd.alloc_length <= MEM_UNITS)
                      && !full && (r_hcnt != {HANDLE_BITS{1'b1}});

    always_comb begin
        ctl            = '0;
        ctl.ins        = (r_cmd.action == ACT_ALLOC) && ok_alloc;
        ctl.ins_len    = ADDR_W'(r_cmd.alloc_length);
        ctl.ins_handle = r_hcnt + 1'b1;
        ctl.del        = (r_cmd.action == ACT_ERASE) && (r_cmd.erase_handle != 16'd0);
        ctl.del_handle = r_cmd.erase_handle;
        ctl.pack       = (r_cmd.action == ACT_DEFRAG);
    end

    // Token enters cell 0 the cycle after accept and passes the register of every
    // cell before it leaves the last; every cell then holds its hit flags.
    ffa_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_start (r_start),
        .i_upd   (upd),
        .i_size  (size_eff),
        .o_done  (done),
        .o_found (found),
        .o_full  (full)
    );

    // A pending result may leave in the same cycle as the next item enters.
    assign o_ready = (r_state == S_IDLE) && (!r_outv || i_ready);
    assign accept  = i_valid && o_ready;
    assign o_valid = r_outv;
    assign o_item  = r_out;

    always_comb begin
        n_state = r_state;
        n_out   = r_out;
        n_outv  = r_outv && !i_ready;
        upd     = 1'b0;
        unique case (r_state)
            S_IDLE: if (accept) n_state = S_RUN;
            S_RUN: begin
                if (done) begin
                    upd     = 1'b1;
                    n_state = S_IDLE;
                    unique case (r_cmd.action)
                        ACT_ALLOC: begin
                            n_outv = 1'b1;
                            if (ctl.ins && found) n_out = '{ST_OK, ctl.ins_handle};
                            else n_out = '{ST_NULL, 16'd0};
                        end
                        ACT_ERASE: if (!(ctl.del && found)) begin
                            n_outv = 1'b1;
                            n_out  = '{ST_ILLEGAL, 16'd0};
                        end
                        default: ;
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_size  <= 8'd128;
            r_hcnt  <= '0;
            r_outv  <= 1'b0;
            r_start <= 1'b0;
        end else begin
            r_state <= n_state;
            r_outv  <= n_outv;
            r_start <= accept;
            if (i_cfg_we) r_size <= i_cfg_wdata;
            if (upd && ctl.ins && found) r_hcnt <= r_hcnt + 1'b1;
        end
        r_out <= n_out;
        if (accept) r_cmd <= i_item;
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("accept while busy");
    a_hcnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hcnt != $past(r_hcnt)) |-> (r_hcnt == $past(r_hcnt) + 1'b1))
        else $error("handle counter jump");
    a_ok_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) && (o_item.status == ST_OK) |-> (o_item.new_handle == r_hcnt))
        else $error("handle mismatch");
`endif
endmodule

// File: test/ffa_checker.sv
// Checker for the first-fit allocator: watches both item channels, predicts results
// from its own copy of the block table, and counts mismatches. Depends on ffa_pkg.
`timescale 1ns / 1ps
module ffa_checker
    import ffa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic      i_valid,
    input  logic      i_ready_in,
    input  t_in_item  i_item,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_item,
    output int        o_errors,
    output int        o_pending,
    output int        o_results
);
    // shadow table, entries 0..blk_count-1 in address order
    int unsigned blk_handle [MAX_BLOCKS];
    int unsigned blk_start  [MAX_BLOCKS];
    int unsigned blk_len    [MAX_BLOCKS];
    int unsigned blk_count;
    int unsigned handles_issued;
    int unsigned size_reg;
    t_out_item   want_q[$];

    task automatic report(input string what, input t_out_item got, input t_out_item exp);
        $display("MISMATCH %s: got status %0d handle %0d, want status %0d handle %0d",
                 what, got.status, got.new_handle, exp.status, exp.new_handle);
        o_errors++;
    endtask

    function automatic void push_result(input logic [1:0] st, input int unsigned h);
        t_out_item r;
        r.status = st;
        r.new_handle = h[15:0];
        want_q = {want_q, r};
    endfunction

    task automatic place_block(input int unsigned len);
        int unsigned lim;
        int unsigned prev_end;
        int unsigned gap_end;
        int unsigned e;
        lim = (size_reg > MEM_UNITS) ? MEM_UNITS : size_reg;
        prev_end = 0;
        if (len == 0 || blk_count >= MAX_BLOCKS ||
            handles_issued >= (1 << HANDLE_BITS) - 1) begin
            push_result(ST_NULL, 0);
            return;
        end
        for (int i = 0; i <= blk_count; i++) begin
            gap_end = (i < blk_count) ? blk_start[i] : lim;
            if (gap_end >= prev_end && gap_end - prev_end >= len) begin
                for (int k = blk_count; k > i; k--) begin
                    blk_handle[k] = blk_handle[k-1];
                    blk_start[k]  = blk_start[k-1];
                    blk_len[k]    = blk_len[k-1];
                end
                handles_issued++;
                blk_handle[i] = handles_issued;
                blk_start[i]  = prev_end;
                blk_len[i]    = len;
                blk_count++;
                push_result(ST_OK, handles_issued);
                return;
            end
            if (i < blk_count) begin
                e = blk_start[i] + blk_len[i];
                if (e > prev_end) prev_end = e;
            end
        end
        push_result(ST_NULL, 0);
    endtask

    task automatic free_block(input int unsigned h);
        if (h != 0) begin
            for (int i = 0; i < blk_count; i++) begin
                if (blk_handle[i] == h) begin
                    for (int k = i; k + 1 < blk_count; k++) begin
                        blk_handle[k] = blk_handle[k+1];
                        blk_start[k]  = blk_start[k+1];
                        blk_len[k]    = blk_len[k+1];
                    end
                    blk_count--;
                    return;
                end
            end
        end
        push_result(ST_ILLEGAL, 0);
    endtask

    assign o_pending = want_q.size();

    always @(posedge i_clk) begin
        t_out_item exp;
        int unsigned nxt;
        if (!i_rst_n) begin
            blk_count = 0;
            handles_issued = 0;
            size_reg = 128;
            want_q.delete();
            o_errors = 0;
            o_results = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                o_results++;
                if (want_q.size() == 0) begin
                    exp = '0;
                    report("unexpected item", i_out_item, exp);
                end else begin
                    exp = want_q.pop_front();
                    if (i_out_item.status !== exp.status)
                        report("status", i_out_item, exp);
                    else if (i_out_item.new_handle !== exp.new_handle)
                        report("handle", i_out_item, exp);
                end
            end
            if (i_cfg_we) size_reg = i_cfg_wdata;
            if (i_valid && i_ready_in) begin
                case (i_item.action)
                    ACT_ALLOC:  place_block(i_item.alloc_length);
                    ACT_ERASE:  free_block(i_item.erase_handle);
                    ACT_DEFRAG: begin
                        nxt = 0;
                        for (int i = 0; i < blk_count; i++) begin
                            blk_start[i] = nxt;
                            nxt += blk_len[i];
                        end
                    end
                    default: ;
                endcase
            end
        end
    end
endmodule

// File: test/first_fit_allocator_with_compaction_core_test.sv
// Testbench top for first_fit_allocator_with_compaction_core: drives commands and
// size settings, gives the verdict. Depends on ffa_pkg, ffa_checker and the core.
`timescale 1ns / 1ps
module first_fit_allocator_with_compaction_core_test;
    import ffa_pkg::*;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cfg_we = 1'b0;
    logic [7:0] cfg_wdata = '0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;
    int        errors, pending, results;
    int        cycles = 0;
    int        items_sent = 0;
    int unsigned last_handle = 0;   // rough tracker for picking live handles
    int unsigned rx_mode = 0;

    localparam int CYCLE_LIMIT = 2000000;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    first_fit_allocator_with_compaction_core DUT (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_valid(in_valid), .o_ready(in_ready), .i_item(in_item),
        .o_valid(out_valid), .i_ready(out_ready), .o_item(out_item)
    );

    ffa_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_valid(in_valid), .i_ready_in(in_ready), .i_item(in_item),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_item(out_item),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    // Timeout watchdog.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("first_fit_allocator_with_compaction_core verification failed");
            $finish;
        end
    end

    // Receiver stall pattern: mode changes now and then; mode 0 never stalls.
    always @(posedge clk) begin
        if ($urandom_range(0, 199) == 0) rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= cycles[2];
        endcase
    end

    // Present one item, hold it until accepted, then drop valid for a cycle.
    task automatic send(input logic [1:0] act, input logic [7:0] len, input logic [15:0] h);
        in_item  <= '{action: act, alloc_length: len, erase_handle: h};
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        in_valid <= 1'b0;
        items_sent++;
        if (act == ACT_ALLOC) last_handle++;
        @(posedge clk);
    endtask

    // Size write only when the block is idle: drain results, wait for the scan to end.
    task automatic set_size(input logic [7:0] v);
        while (pending != 0 || !in_ready) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Random item mix: mostly allocs and erases of likely-live handles.
    task automatic random_item(input int max_len);
        int unsigned r;
        logic [15:0] h;
        r = $urandom_range(0, 99);
        if (r < 45)
            send(ACT_ALLOC, 8'($urandom_range(1, max_len)), 16'($urandom));
        else if (r < 80) begin
            h = (last_handle == 0) ? 16'd1 : 16'($urandom_range(1, last_handle));
            send(ACT_ERASE, 8'($urandom), h);
        end else if (r < 90)
            send(ACT_DEFRAG, 8'($urandom), 16'($urandom));
        else if (r < 94)
            send(ACT_ERASE, 8'($urandom), 16'($urandom));
        else if (r < 97)
            send(ACT_ALLOC, (r[0] ? 8'd0 : 8'($urandom)), 16'($urandom));
        else
            send(ACT_UNUSED, 8'($urandom), 16'($urandom));
    endtask

    initial begin
        int burst;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, full fill, gaps, illegal erases, defrag, unused action.
        send(ACT_ALLOC, 8'd0, 16'hFFFF);        // zero length
        send(ACT_ALLOC, 8'd128, 16'h0);         // whole memory
        send(ACT_ALLOC, 8'd1, 16'h0);           // no space
        send(ACT_ERASE, 8'hFF, 16'd0);          // handle zero
        send(ACT_ERASE, 8'h00, 16'hFFFF);       // never given out
        send(ACT_ERASE, 8'h00, 16'd1);
        send(ACT_ERASE, 8'h00, 16'd1);          // already erased
        send(ACT_ALLOC, 8'd255, 16'h0);         // larger than memory
        send(ACT_ALLOC, 8'd10, 16'h0);
        send(ACT_ALLOC, 8'd20, 16'h0);
        send(ACT_ALLOC, 8'd30, 16'h0);
        send(ACT_ERASE, 8'h0, 16'd3);           // hole in the middle
        send(ACT_ALLOC, 8'd25, 16'h0);          // too big for the hole, placed after the last block
        send(ACT_ALLOC, 8'd90, 16'h0);          // too big before defrag
        send(ACT_DEFRAG, 8'h0, 16'h0);
        send(ACT_ALLOC, 8'd73, 16'h0);          // more than the rest
        send(ACT_UNUSED, 8'hFF, 16'hFFFF);      // unused action
        set_size(8'd40);                        // shrink under live blocks
        send(ACT_ALLOC, 8'd1, 16'h0);
        set_size(8'd0);
        send(ACT_ALLOC, 8'd1, 16'h0);
        set_size(8'd255);                       // above range clamps
        send(ACT_DEFRAG, 8'h0, 16'h0);
        send(ACT_ALLOC, 8'd1, 16'h0);

        // Random phases over several sizes; small lengths mostly keep the table busy.
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: set_size(8'd128);
                1: set_size(8'd1);
                2: set_size(8'd16);
                3: set_size(8'd200);
                4: set_size(8'd64);
                5: set_size(8'd7);
                6: set_size(8'd128);
                default: set_size(8'($urandom_range(1, 128)));
            endcase
            for (int n = 0; n < 250; ) begin
                burst = (n % 3 == 0) ? 40 : $urandom_range(1, 12);
                for (int b = 0; b < burst && n < 250; b++, n++)
                    random_item(($urandom_range(0, 9) == 0) ? 128 : 6);
                if ($urandom_range(0, 1)) repeat ($urandom_range(1, 10)) @(posedge clk);
                if (n == 125) while (pending != 0) @(posedge clk);   // full drain
            end
        end

        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("sent %0d command items over 8 size settings, checked %0d results",
                 items_sent, results);
        if (errors == 0)
            $display("first_fit_allocator_with_compaction_core verification clean");
        else
            $display("first_fit_allocator_with_compaction_core verification failed");
        $finish;
    end
endmodule

// File: files.f
sv/ffa_pkg.sv
sv/ffa_cell.sv
sv/ffa_chain.sv
sv/first_fit_allocator_with_compaction_core.sv
test/ffa_checker.sv
test/first_fit_allocator_with_compaction_core_test.sv
